@@ rtl/stb_pkg.sv @@
package stb_pkg;

  localparam int STB_NUM_TIMERS = 8;
  localparam int CNT_W = 16;
  localparam int IDX_W = 3;
  localparam int MASK_W = 8;

  typedef logic [2:0] req_t;

  localparam req_t REQ_TICK   = 3'd0;
  localparam req_t REQ_START  = 3'd1;
  localparam req_t REQ_STOP   = 3'd2;
  localparam req_t REQ_RELOAD = 3'd3;
  localparam req_t REQ_SET    = 3'd4;

  typedef struct packed {
    logic in_ready;
    logic ptr_clr;
    logic en_wr;
    logic set_wr;
    logic rld_rd;
    logic rld_wr;
    logic tick_rd;
    logic cnt_rd;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    req_t req;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/stb_req_if.sv @@
interface stb_req_if
  import stb_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [IDX_W-1:0]   tmr_sel;
  logic [CNT_W-1:0]   count_value;

  modport source (output valid, output req_type, output tmr_sel, output count_value,
                  input ready);
  modport sink (input valid, input req_type, input tmr_sel, input count_value,
                output ready);
endinterface

@@ rtl/stb_rsp_if.sv @@
interface stb_rsp_if
  import stb_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               is_expired;
  logic [CNT_W-1:0]   remaining;
  logic [MASK_W-1:0]  expired_mask;

  modport source (output valid, output is_expired, output remaining, output expired_mask,
                  input ready);
  modport sink (input valid, input is_expired, input remaining, input expired_mask,
                output ready);
endinterface

@@ rtl/stb_ctrl.sv @@
module stb_ctrl
  import stb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMD   = 3'd1;
  localparam logic [2:0] S_RLD   = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    ctl = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (stat.in_valid) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        unique case (stat.req) inside
          REQ_TICK: begin
            ctl.ptr_clr = 1'b1;
            state_nxt = S_TICK;
          end
          REQ_START, REQ_STOP: begin
            ctl.en_wr = 1'b1;
            state_nxt = S_RD;
          end
          REQ_RELOAD: begin
            ctl.rld_rd = 1'b1;
            state_nxt = S_RLD;
          end
          REQ_SET: begin
            ctl.set_wr = 1'b1;
            state_nxt = S_RD;
          end
          default: begin
            state_nxt = S_RD;
          end
        endcase
      end
      S_RLD: begin
        ctl.rld_wr = 1'b1;
        state_nxt = S_RD;
      end
      S_TICK: begin
        ctl.tick_rd = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RD;
      end
      S_RD: begin
        ctl.cnt_rd = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.in_ready && stat.in_valid) |=> (state_r == S_CMD))
    else $error("accepted request was not dispatched");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && stat.sweep_last) |=> (state_r == S_DRAIN))
    else $error("tick sweep did not end after the last timer");

  a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> (state_r == S_IDLE && ctl.in_ready))
    else $error("block not ready after the report was loaded");
`endif

endmodule

@@ rtl/stb_datapath.sv @@
module stb_datapath
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = STB_NUM_TIMERS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_t     ctl,
  output stat_t     stat,
  stb_req_if.sink   in_ch,
  stb_rsp_if.source out_ch
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MW = (NUM_TIMERS < MASK_W) ? NUM_TIMERS : MASK_W;

  req_t              req_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  val_r;

  logic [AW-1:0]     ptr_r;
  logic              pipe_v_r;
  logic [AW-1:0]     pipe_addr_r;

  logic [NUM_TIMERS-1:0] en_r;
  logic [NUM_TIMERS-1:0] exp_r;
  logic [NUM_TIMERS-1:0] cnt_vld_r;
  logic [NUM_TIMERS-1:0] rld_vld_r;

  logic [CNT_W-1:0]  cnt_mem [NUM_TIMERS];
  logic [CNT_W-1:0]  rld_mem [NUM_TIMERS];
  logic [CNT_W-1:0]  cnt_rd_r;
  logic              cnt_rd_vld_r;
  logic [CNT_W-1:0]  rld_rd_r;
  logic              rld_rd_vld_r;

  logic              out_valid_r;
  logic              out_exp_r;
  logic [CNT_W-1:0]  out_rem_r;
  logic [MASK_W-1:0] out_mask_r;

  logic              idx_ok;
  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW-1:0]     idx_addr;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W-1:0]  rld_eff;
  logic [CNT_W-1:0]  tick_cnt;
  logic              tick_upd;
  logic              cnt_we;
  logic [AW-1:0]     cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              cnt_re;
  logic [AW-1:0]     cnt_raddr;
  logic              set_ok;
  logic [MASK_W-1:0] mask;

  assign idx_ok   = (32'(idx_r) < NUM_TIMERS);
  assign idx_ext  = {{AW{1'b0}}, idx_r};
  assign idx_addr = idx_ext[AW-1:0];
  assign set_ok   = ctl.set_wr && idx_ok;

  assign cnt_eff  = cnt_rd_vld_r ? cnt_rd_r : '0;
  assign rld_eff  = rld_rd_vld_r ? rld_rd_r : '0;
  assign tick_cnt = (cnt_eff != '0) ? (cnt_eff - CNT_W'(1)) : '0;
  assign tick_upd = pipe_v_r && en_r[pipe_addr_r];

  assign cnt_re    = ctl.tick_rd || ctl.cnt_rd;
  assign cnt_raddr = ctl.tick_rd ? ptr_r : idx_addr;
  assign mask      = MASK_W'(exp_r[MW-1:0]);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx_addr;
    cnt_wdata = val_r;
    if (tick_upd) begin
      cnt_we    = 1'b1;
      cnt_waddr = pipe_addr_r;
      cnt_wdata = tick_cnt;
    end else if (set_ok) begin
      cnt_we    = 1'b1;
    end else if (ctl.rld_wr && idx_ok) begin
      cnt_we    = 1'b1;
      cnt_wdata = rld_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.in_ready && in_ch.valid) begin
      req_r <= in_ch.req_type;
      idx_r <= in_ch.tmr_sel;
      val_r <= in_ch.count_value;
    end
    if (ctl.tick_rd) begin
      pipe_addr_r <= ptr_r;
    end
    if (ctl.out_load) begin
      out_exp_r  <= idx_ok ? exp_r[idx_addr] : 1'b0;
      out_rem_r  <= idx_ok ? cnt_eff : '0;
      out_mask_r <= mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_r     <= cnt_mem[cnt_raddr];
      cnt_rd_vld_r <= cnt_vld_r[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (set_ok) begin
      rld_mem[idx_addr] <= val_r;
    end
    if (ctl.rld_rd) begin
      rld_rd_r     <= rld_mem[idx_addr];
      rld_rd_vld_r <= rld_vld_r[idx_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      pipe_v_r    <= 1'b0;
      en_r        <= '0;
      exp_r       <= '0;
      cnt_vld_r   <= '0;
      rld_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.ptr_clr) begin
        ptr_r <= '0;
      end else if (ctl.tick_rd) begin
        ptr_r <= ptr_r + AW'(1);
      end
      pipe_v_r <= ctl.tick_rd;
      if (ctl.en_wr && idx_ok) begin
        en_r[idx_addr] <= (req_r == REQ_START);
      end
      if (tick_upd && (tick_cnt == '0)) begin
        exp_r[pipe_addr_r] <= 1'b1;
      end
      if (ctl.rld_wr && idx_ok) begin
        exp_r[idx_addr] <= 1'b0;
      end
      if (cnt_we) begin
        cnt_vld_r[cnt_waddr] <= 1'b1;
      end
      if (set_ok) begin
        rld_vld_r[idx_addr] <= 1'b1;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready         = ctl.in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_expired   = out_exp_r;
  assign out_ch.remaining    = out_rem_r;
  assign out_ch.expired_mask = out_mask_r;

  assign stat.in_valid   = in_ch.valid;
  assign stat.req        = req_r;
  assign stat.sweep_last = (ptr_r == AW'(NUM_TIMERS - 1));
  assign stat.out_free   = !out_valid_r || out_ch.ready;

endmodule

@@ rtl/software_timer_bank_top.sv @@
// Bank of NUM_TIMERS 16-bit down-counting timers driven by one request at a time
// (tick, start, stop, reload, set count), each answered by one report with the addressed
// timer's expired flag and count and the expired mask of timers 0 to 7 (or of all timers
// if fewer). Counts live in a memory with one read and one write port, setpoints in a
// single-port memory; a tick sweeps the count memory one timer per cycle, then drains,
// reads the addressed count and loads the report. Reload first copies the setpoint to
// the count. Loading the report waits until the output register is free.
// The report sits in an output register, so a new request is taken while it waits.
module software_timer_bank_top
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = STB_NUM_TIMERS
) (
  input  logic      clk,
  input  logic      rst_n,
  stb_req_if.sink   in_ch,
  stb_rsp_if.source out_ch
);

  ctrl_t ctl;
  stat_t stat;

  stb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  stb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
